FILE: sv/tclcs_pkg.sv
package tclcs_pkg;

	typedef struct packed {
		logic               command;
		logic [3:0]         row_index;
		logic signed [11:0] row_current;
		logic signed [23:0] row_power_low;
		logic signed [23:0] row_power_high;
		logic signed [15:0] lens_temperature;
		logic signed [23:0] power_target;
		logic signed [11:0] present_current;
	} in_item_t;

	typedef struct packed {
		logic signed [12:0] current_setpoint;
		logic [12:0]        correction_size;
		logic               extrapolated;
	} out_item_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_CAL_TEMP_LOW  = 1'b0;
	localparam logic REG_CAL_TEMP_HIGH = 1'b1;

	localparam logic signed [15:0] CAL_TEMP_LOW_RESET  = 16'sd7680;
	localparam logic signed [15:0] CAL_TEMP_HIGH_RESET = 16'sd11520;
	localparam int SETPOINT_MAX = 4095;

	// row power width: a one-count temperature span can push it near 2^40
	localparam int PW = 42;

	// divider operand widths
	localparam int DIV_N = 56;
	localparam int DIV_D = 44;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_START,
		OP_ROW_RD,
		OP_ROW_MUL,
		OP_ROW_DIV,
		OP_ROW_WAIT,
		OP_ROW_STORE,
		OP_SEG_RD,
		OP_SEG_MUL,
		OP_SEG_DIV,
		OP_SEG_WAIT,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic div_busy;
		logic row_last;
	} dp_status_t;

endpackage

FILE: sv/tclcs_divider.sv
module tclcs_divider
	import tclcs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_N-1:0] numer,
	input  logic signed [DIV_D-1:0] denom,
	output logic                    busy,
	output logic signed [DIV_N-1:0] quot
);

	localparam int CW = $clog2(DIV_N + 1);

	logic [DIV_N-1:0] q_q;
	logic [DIV_D:0]   rem_q;
	logic [DIV_D-1:0] dabs_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DIV_D:0]   trial;
	logic [DIV_D:0]   shifted;

	assign shifted = {rem_q[DIV_D-1:0], q_q[DIV_N-1]};
	assign trial   = shifted - {1'b0, dabs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIV_N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= numer[DIV_N-1] ? DIV_N'(-numer) : numer;
			dabs_q <= denom[DIV_D-1] ? DIV_D'(-denom) : denom;
			neg_q  <= numer[DIV_N-1] ^ denom[DIV_D-1];
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!trial[DIV_D]) begin
				rem_q <= trial;
				q_q   <= {q_q[DIV_N-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[DIV_N-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? DIV_N'(-q_q) : q_q;

endmodule

FILE: sv/tclcs_datapath.sv
module tclcs_datapath
	import tclcs_pkg::*;
#(
	parameter int TABLE_ROWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_op_t      op,
	input  in_item_t    in_item,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output dp_status_t  status,
	output out_item_t   out_item
);

	localparam int RW = $clog2(TABLE_ROWS);

	logic signed [11:0]   cur_mem [TABLE_ROWS];
	logic signed [23:0]   pl_mem  [TABLE_ROWS];
	logic signed [23:0]   ph_mem  [TABLE_ROWS];
	logic signed [PW-1:0] pw_mem  [TABLE_ROWS];

	logic signed [15:0]      tlo_q, thi_q;
	in_item_t                q_q;
	logic [RW-1:0]           row_q;
	logic [RW-1:0]           seg_q;
	logic signed [11:0]      cur_rd_q;
	logic signed [23:0]      pl_rd_q, ph_rd_q;
	logic signed [PW-1:0]    pw_rd_q;
	logic signed [11:0]      cl_q;
	logic signed [PW-1:0]    pl_seg_q;
	logic signed [PW-1:0]    p0_q, plast_q;
	logic signed [DIV_N-1:0] num_q;
	logic signed [DIV_D-1:0] den_q;
	logic                    zero_den_q;
	logic                    rd_phase_q;
	out_item_t               res_q;

	logic signed [16:0]      d_w, dt_w;
	logic signed [DIV_N-1:0] quot;
	logic                    div_busy, div_start;
	logic signed [PW-1:0]    pnew;
	logic signed [DIV_N:0]   sp_w;
	logic signed [13:0]      sp_sat;
	logic signed [14:0]      corr;
	logic signed [16:0]      tmin, tmax;

	assign d_w  = 17'(thi_q) - 17'(tlo_q);
	assign dt_w = 17'(q_q.lens_temperature) - 17'(tlo_q);
	assign div_start = (op == OP_ROW_DIV) || (op == OP_SEG_DIV);

	tclcs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.numer(num_q), .denom(den_q), .busy(div_busy), .quot(quot)
	);

	assign pnew = zero_den_q ? PW'(pl_rd_q) : PW'(pl_rd_q) + PW'(quot);
	assign sp_w = zero_den_q ? (DIV_N+1)'(cl_q) : (DIV_N+1)'(cl_q) + (DIV_N+1)'(quot);
	assign sp_sat = (sp_w > (DIV_N+1)'(SETPOINT_MAX)) ? 14'(SETPOINT_MAX) :
		(sp_w < -(DIV_N+1)'(SETPOINT_MAX)) ? -14'(SETPOINT_MAX) : 14'(sp_w);
	assign corr = 15'(sp_sat) - 15'(q_q.present_current);
	assign tmin = (tlo_q < thi_q) ? 17'(tlo_q) : 17'(thi_q);
	assign tmax = (tlo_q < thi_q) ? 17'(thi_q) : 17'(tlo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlo_q <= CAL_TEMP_LOW_RESET;
			thi_q <= CAL_TEMP_HIGH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CAL_TEMP_LOW)
				tlo_q <= cfg_data;
			else
				thi_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (32'(in_item.row_index) < TABLE_ROWS) begin
					cur_mem[RW'(in_item.row_index)] <= in_item.row_current;
					pl_mem[RW'(in_item.row_index)]  <= in_item.row_power_low;
					ph_mem[RW'(in_item.row_index)]  <= in_item.row_power_high;
				end
			end
			OP_START: begin
				q_q   <= in_item;
				row_q <= '0;
				seg_q <= '0;
			end
			OP_ROW_RD: begin
				pl_rd_q <= pl_mem[row_q];
				ph_rd_q <= ph_mem[row_q];
			end
			OP_ROW_MUL: begin
				num_q      <= DIV_N'(dt_w * (25'(ph_rd_q) - 25'(pl_rd_q)));
				den_q      <= DIV_D'(d_w);
				zero_den_q <= (d_w == 17'sd0);
			end
			OP_ROW_STORE: begin
				pw_mem[row_q] <= pnew;
				if (row_q == RW'(0))
					p0_q <= pnew;
				if (row_q == RW'(TABLE_ROWS - 1))
					plast_q <= pnew;
				if (row_q != RW'(TABLE_ROWS - 1) && pnew <= PW'(q_q.power_target))
					seg_q <= row_q;
				row_q      <= row_q + 1'b1;
				rd_phase_q <= 1'b0;
			end
			OP_SEG_RD: begin
				pw_rd_q    <= pw_mem[rd_phase_q ? RW'(seg_q + 1'b1) : seg_q];
				cur_rd_q   <= cur_mem[rd_phase_q ? RW'(seg_q + 1'b1) : seg_q];
				rd_phase_q <= 1'b1;
				if (rd_phase_q) begin
					pl_seg_q <= pw_rd_q;
					cl_q     <= cur_rd_q;
				end
			end
			OP_SEG_MUL: begin
				num_q      <= DIV_N'(((PW+1)'(q_q.power_target) - (PW+1)'(pl_seg_q))
					* (13'(cur_rd_q) - 13'(cl_q)));
				den_q      <= DIV_D'((PW+1)'(pw_rd_q) - (PW+1)'(pl_seg_q));
				zero_den_q <= (pw_rd_q == pl_seg_q);
			end
			OP_FINISH: begin
				res_q.current_setpoint <= 13'(sp_sat);
				res_q.correction_size  <= 13'(corr < 0 ? -corr : corr);
				res_q.extrapolated     <= (17'(q_q.lens_temperature) < tmin) ||
					(17'(q_q.lens_temperature) > tmax) ||
					(PW'(q_q.power_target) < p0_q) ||
					(PW'(q_q.power_target) > plast_q);
			end
			default: ;
		endcase
	end

	assign status.div_busy = div_busy;
	assign status.row_last = (row_q == RW'(TABLE_ROWS - 1));
	assign out_item = res_q;

endmodule

FILE: sv/tclcs_ctrl.sv
module tclcs_ctrl
	import tclcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_command,
	output logic       in_stall,
	input  logic       out_stall,
	output logic       out_valid,
	input  dp_status_t status,
	output dp_op_t     op
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RRD    = 4'd1;
	localparam logic [3:0] S_RMUL   = 4'd2;
	localparam logic [3:0] S_RDIV   = 4'd3;
	localparam logic [3:0] S_RWAIT  = 4'd4;
	localparam logic [3:0] S_RSTORE = 4'd5;
	localparam logic [3:0] S_SRD0   = 4'd6;
	localparam logic [3:0] S_SRD1   = 4'd7;
	localparam logic [3:0] S_SMUL   = 4'd8;
	localparam logic [3:0] S_SDIV   = 4'd9;
	localparam logic [3:0] S_SWAIT  = 4'd10;
	localparam logic [3:0] S_FIN    = 4'd11;

	logic [3:0] state_q;
	logic       ovalid_q;
	logic       take;

	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && (state_q == S_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:   op = take ? (in_command == CMD_QUERY ? OP_START : OP_LOAD) : OP_IDLE;
			S_RRD:    op = OP_ROW_RD;
			S_RMUL:   op = OP_ROW_MUL;
			S_RDIV:   op = OP_ROW_DIV;
			S_RWAIT:  op = OP_ROW_WAIT;
			S_RSTORE: op = OP_ROW_STORE;
			S_SRD0:   op = OP_SEG_RD;
			S_SRD1:   op = OP_SEG_RD;
			S_SMUL:   op = OP_SEG_MUL;
			S_SDIV:   op = OP_SEG_DIV;
			S_SWAIT:  op = OP_SEG_WAIT;
			S_FIN:    op = (ovalid_q && out_stall) ? OP_IDLE : OP_FINISH;
			default:  op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && !(ovalid_q && out_stall))
				ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (take && in_command == CMD_QUERY) state_q <= S_RRD;
				S_RRD:    state_q <= S_RMUL;
				S_RMUL:   state_q <= S_RDIV;
				S_RDIV:   state_q <= S_RWAIT;
				S_RWAIT:  if (!status.div_busy) state_q <= S_RSTORE;
				S_RSTORE: state_q <= status.row_last ? S_SRD0 : S_RRD;
				S_SRD0:   state_q <= S_SRD1;
				S_SRD1:   state_q <= S_SMUL;
				S_SMUL:   state_q <= S_SDIV;
				S_SDIV:   state_q <= S_SWAIT;
				S_SWAIT:  if (!status.div_busy) state_q <= S_FIN;
				S_FIN:    if (!(ovalid_q && out_stall)) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/temp_compensated_lens_current_setpoint_top.sv
// Temperature-compensated lens current setpoint.
// Input channel (in_valid/in_stall/in_data): a load item writes one
// calibration row and gives no result; a query item gives one result on
// the output channel (out_valid/out_stall/out_data).
// Loads may follow back to back. A query runs each of the TABLE_ROWS
// rows through a shared 56-step serial divider, then one more division
// for the segment. The next item is not taken before the query's result
// has been written to the output register.
// in_stall is high while a query is being worked. The result sits in an
// output register; a receiver stall holds it, and a following query stalls
// at its end until the register is free.
// cal_temp_low (index 0) and cal_temp_high (index 1) are written through
// cfg_we/cfg_index/cfg_data by the user, only while idle; not enforced.
// Reset clears the control state and restores the calibration temperatures
// to 30 and 45 deg C; table rows are undefined until loaded.
module temp_compensated_lens_current_setpoint_top
	import tclcs_pkg::*;
#(
	parameter int TABLE_ROWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	dp_op_t     op;
	dp_status_t status;

	tclcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_command(in_data.command), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid),
		.status(status), .op(op)
	);

	tclcs_datapath #(.TABLE_ROWS(TABLE_ROWS)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .in_item(in_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.status(status), .out_item(out_data)
	);

endmodule

FILE: test/temp_compensated_lens_current_setpoint_top_test.sv
`timescale 1ns / 1ps

module temp_compensated_lens_current_setpoint_top_test;
	import tclcs_pkg::*;

	localparam int ROWS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_CAL_TEMP_LOW;
	logic [15:0] cfg_data = '0;

	temp_compensated_lens_current_setpoint_top #(.TABLE_ROWS(ROWS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} vec_t;

	logic signed [15:0] cal_lo = CAL_TEMP_LOW_RESET;
	logic signed [15:0] cal_hi = CAL_TEMP_HIGH_RESET;
	logic signed [11:0] cur_tab [ROWS];
	logic signed [23:0] pwr_lo_tab [ROWS];
	logic signed [23:0] pwr_hi_tab [ROWS];

	out_item_t setpt_q[$];
	int errs = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	function automatic out_item_t predict_setpoint(in_item_t q);
		longint d, dt, num, den, sp, corr, tgt, tmin, tmax, t;
		longint pw [ROWS];
		int l;
		out_item_t o;
		d = longint'(cal_hi) - longint'(cal_lo);
		t = longint'(q.lens_temperature);
		tgt = longint'(q.power_target);
		dt = t - longint'(cal_lo);
		for (int i = 0; i < ROWS; i++) begin
			pw[i] = longint'(pwr_lo_tab[i]);
			if (d != 0)
				pw[i] += (dt * (longint'(pwr_hi_tab[i]) - longint'(pwr_lo_tab[i]))) / d;
		end
		l = 0;
		for (int i = 0; i < ROWS - 1; i++)
			if (pw[i] <= tgt)
				l = i;
		den = pw[l + 1] - pw[l];
		if (den == 0)
			sp = longint'(cur_tab[l]);
		else begin
			num = (tgt - pw[l]) * (longint'(cur_tab[l + 1]) - longint'(cur_tab[l]));
			sp = longint'(cur_tab[l]) + num / den;
		end
		if (sp > SETPOINT_MAX)
			sp = SETPOINT_MAX;
		if (sp < -SETPOINT_MAX)
			sp = -SETPOINT_MAX;
		corr = sp - longint'(q.present_current);
		if (corr < 0)
			corr = -corr;
		tmin = (cal_lo < cal_hi) ? longint'(cal_lo) : longint'(cal_hi);
		tmax = (cal_lo < cal_hi) ? longint'(cal_hi) : longint'(cal_lo);
		o.current_setpoint = sp[12:0];
		o.correction_size = corr[12:0];
		o.extrapolated = (t < tmin) || (t > tmax) || (tgt < pw[0]) || (tgt > pw[ROWS - 1]);
		return o;
	endfunction

	function automatic in_item_t load_item(int idx, int cur, int pl, int ph);
		in_item_t it;
		it = '0;
		it.command = CMD_LOAD;
		it.row_index = idx[3:0];
		it.row_current = cur[11:0];
		it.row_power_low = pl[23:0];
		it.row_power_high = ph[23:0];
		return it;
	endfunction

	function automatic in_item_t query_item(int t, int tgt, int pres);
		in_item_t it;
		it = '0;
		it.command = CMD_QUERY;
		it.lens_temperature = t[15:0];
		it.power_target = tgt[23:0];
		it.present_current = pres[11:0];
		return it;
	endfunction

	function automatic out_item_t result(int sp, int corr, bit ex);
		out_item_t o;
		o.current_setpoint = sp[12:0];
		o.correction_size = corr[12:0];
		o.extrapolated = ex;
		return o;
	endfunction

	task automatic send(input in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.command == CMD_QUERY)
			setpt_q.push_back(predict_setpoint(it));
		else begin
			cur_tab[it.row_index] = it.row_current;
			pwr_lo_tab[it.row_index] = it.row_power_low;
			pwr_hi_tab[it.row_index] = it.row_power_high;
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (setpt_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_cal(input int lo, input int hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_CAL_TEMP_LOW;
		cfg_data <= lo[15:0];
		@(posedge clk);
		cfg_index <= REG_CAL_TEMP_HIGH;
		cfg_data <= hi[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cal_lo = lo[15:0];
		cal_hi = hi[15:0];
	endtask

	function automatic int rand_span(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (setpt_q.size() == 0) begin
				$error("result with nothing pending: %p", out_data);
				errs++;
			end else begin
				out_item_t w;
				w = setpt_q.pop_front();
				if (out_data.current_setpoint !== w.current_setpoint) begin
					$error("current_setpoint exp %0d got %0d", w.current_setpoint,
						out_data.current_setpoint);
					errs++;
				end
				if (out_data.correction_size !== w.correction_size) begin
					$error("correction_size exp %0d got %0d", w.correction_size,
						out_data.correction_size);
					errs++;
				end
				if (out_data.extrapolated !== w.extrapolated) begin
					$error("extrapolated exp %0b got %0b", w.extrapolated,
						out_data.extrapolated);
					errs++;
				end
			end
		end
	end

	// receiver: short random stalls, one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else
				@(posedge clk);
		end
	end

	initial begin
		#60_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		vec_t dir[$];
		int cal_set [5][2];
		int row_ptr, n, tmin, tmax;
		in_item_t it;

		cal_set = '{'{7680, 11520}, '{-32768, 32767}, '{32767, -32768},
			'{1000, 1000}, '{0, 0}};
		cal_set[4][0] = rand_span(-32768, 32767);
		cal_set[4][1] = rand_span(-32768, 32767);

		for (int i = 0; i < ROWS; i++)
			dir.push_back('{load_item(i, i * 100 - 800, i * 65536, i * 65536), 0, '0});
		dir.push_back('{query_item(9600, 3 * 65536, 0), 1, result(-500, 500, 0)});
		dir.push_back('{query_item(9600, -8388608, -2048), 1, result(-4095, 2047, 1)});
		dir.push_back('{query_item(9600, 8388607, -2048), 1, result(4095, 6143, 1)});
		dir.push_back('{query_item(-32768, 5 * 65536, 0), 1, result(-300, 300, 1)});
		dir.push_back('{query_item(32767, 5 * 65536, 2047), 1, result(-300, 2347, 1)});
		dir.push_back('{load_item(0, -2048, -8388608, 8388607), 0, '0});
		dir.push_back('{load_item(15, 2047, 8388607, -8388608), 0, '0});
		dir.push_back('{query_item(9600, 1000, 1), 0, '0});
		// rows 0 and 1 share power: a target under both lands on a flat segment
		dir.push_back('{load_item(1, -1000, -8388608, 8388607), 0, '0});
		dir.push_back('{query_item(11520, 0, 0), 1, result(-2048, 2048, 1)});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[k]) begin
			send(dir[k].stim);
			if (dir[k].typed)
				setpt_q[$] = dir[k].want;
		end
		drain();

		row_ptr = 0;
		for (int ph = 0; ph < 5; ph++) begin
			set_cal(cal_set[ph][0], cal_set[ph][1]);
			tmin = (cal_lo < cal_hi) ? int'(cal_lo) : int'(cal_hi);
			tmax = (cal_lo < cal_hi) ? int'(cal_hi) : int'(cal_lo);
			n = 276;
			for (int k = 0; k < n; k++) begin
				if (ph == 4 && k >= n - 120)
					quiet = 1'b1;
				if (ph == 1 && k == 60)
					hold_req = 1'b1;
				if (k == 150) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (setpt_q.size() != 0)
						@(posedge clk);
				end else if (!quiet && $urandom_range(0, 3) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end
				if ($urandom_range(0, 9) < 4) begin
					if ($urandom_range(0, 9) == 0)
						it = load_item($urandom, $urandom, $urandom, $urandom);
					else
						it = load_item(row_ptr,
							-2048 + row_ptr * 256 + int'($urandom_range(0, 255)),
							-8388608 + row_ptr * 1048576 + int'($urandom_range(0, 1048575)),
							-8388608 + row_ptr * 1048576 + int'($urandom_range(0, 1048575)));
					row_ptr = (row_ptr + 1) % ROWS;
				end else begin
					it = query_item(($urandom_range(0, 9) < 7) ? rand_span(tmin, tmax) : $urandom,
						$urandom, $urandom);
				end
				send(it);
			end
			drain();
		end

		for (int w = 0; w < 2000 && setpt_q.size() != 0; w++)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (errs == 0 && setpt_q.size() == 0)
			$display("DONE: 0 errors");
		else begin
			if (setpt_q.size() != 0)
				$error("%0d results never arrived", setpt_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
